// File: rtl/pfe_pkg.sv
// shared types, constants and control store of the postfix evaluator
package pfe_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 31;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = 4;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_SLASH = 8'd47;

    localparam logic [ACC_W-1:0] NUM_MAX = {ACC_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        U_NOP,
        U_ACCEPT,
        U_DIGIT,
        U_FLUSH,
        U_READ_R,
        U_READ_L,
        U_POP,
        U_ALU,
        U_DIV_GO,
        U_DIV_TAKE,
        U_PUSH_RES,
        U_READ_TOP,
        U_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DIGIT,
        C_NOT_OPER,
        C_FEW,
        C_DIV,
        C_R_ZERO,
        C_DIV_BUSY,
        C_NOT_LAST,
        C_OUT_BUSY
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_WAIT   = 4'd0;
    localparam step_t S_DIGIT  = 4'd1;
    localparam step_t S_FLUSH  = 4'd2;
    localparam step_t S_OPCHK  = 4'd3;
    localparam step_t S_RDL    = 4'd4;
    localparam step_t S_POP    = 4'd5;
    localparam step_t S_ALU    = 4'd6;
    localparam step_t S_DIVGO  = 4'd7;
    localparam step_t S_DIVWT  = 4'd8;
    localparam step_t S_PUSH   = 4'd9;
    localparam step_t S_ENDCHK = 4'd10;
    localparam step_t S_FLUSH2 = 4'd11;
    localparam step_t S_TOPRD  = 4'd12;
    localparam step_t S_EMIT   = 4'd13;
    localparam step_t S_BACK   = 4'd14;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // condition inputs from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic is_digit;
        logic is_oper;
        logic is_div;
        logic few;
        logic r_zero;
        logic div_done;
        logic last;
        logic out_busy;
    } seq_flags_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            S_WAIT:   w = '{op: U_ACCEPT,   cond: C_NO_INPUT, target: S_WAIT};
            S_DIGIT:  w = '{op: U_DIGIT,    cond: C_DIGIT,    target: S_ENDCHK};
            S_FLUSH:  w = '{op: U_FLUSH,    cond: C_NOT_OPER, target: S_ENDCHK};
            S_OPCHK:  w = '{op: U_READ_R,   cond: C_FEW,      target: S_ENDCHK};
            S_RDL:    w = '{op: U_READ_L,   cond: C_NEVER,    target: S_WAIT};
            S_POP:    w = '{op: U_POP,      cond: C_DIV,      target: S_DIVGO};
            S_ALU:    w = '{op: U_ALU,      cond: C_ALWAYS,   target: S_PUSH};
            S_DIVGO:  w = '{op: U_DIV_GO,   cond: C_R_ZERO,   target: S_PUSH};
            S_DIVWT:  w = '{op: U_DIV_TAKE, cond: C_DIV_BUSY, target: S_DIVWT};
            S_PUSH:   w = '{op: U_PUSH_RES, cond: C_NEVER,    target: S_WAIT};
            S_ENDCHK: w = '{op: U_NOP,      cond: C_NOT_LAST, target: S_WAIT};
            S_FLUSH2: w = '{op: U_FLUSH,    cond: C_NEVER,    target: S_WAIT};
            S_TOPRD:  w = '{op: U_READ_TOP, cond: C_NEVER,    target: S_WAIT};
            S_EMIT:   w = '{op: U_EMIT,     cond: C_OUT_BUSY, target: S_EMIT};
            S_BACK:   w = '{op: U_NOP,      cond: C_ALWAYS,   target: S_WAIT};
            default:  w = '{op: U_NOP,      cond: C_ALWAYS,   target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/pfe_if.sv
// character and result channel interfaces
interface pfe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_expr;

    modport source (output valid, output char_code, output end_of_expr, input ready);
    modport sink   (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface pfe_result_if;
    import pfe_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    status_t            status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// File: rtl/pfe_ram.sv
// generic single write, single read ram with registered read data
module pfe_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/pfe_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module pfe_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfe_pkg::DATA_W-1:0]  dividend,
    input  logic [pfe_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [pfe_pkg::DATA_W-1:0]  quotient
);
    import pfe_pkg::*;

    localparam int IT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [IT_W-1:0]   it_reg, it_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_shift = {rem_reg, quo_reg[DATA_W-1]};
        trial     = rem_shift - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            it_next   = {IT_W{1'b1}};
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            it_next = it_reg - 1'b1;
            if (it_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg  <= it_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
endmodule

// File: rtl/pfe_seq.sv
// microcode sequencer: step counter, control store lookup, conditional jumps
module pfe_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  pfe_pkg::seq_flags_t flags,
    output pfe_pkg::uop_t       uop
);
    import pfe_pkg::*;

    step_t  step_reg, step_next;
    ucode_t word;
    logic   take;

    always_comb
    begin
        word = ucode_rom(step_reg);
        case (word.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_INPUT: take = !flags.in_valid;
            C_DIGIT:    take = flags.is_digit;
            C_NOT_OPER: take = !flags.is_oper;
            C_FEW:      take = flags.few;
            C_DIV:      take = flags.is_div;
            C_R_ZERO:   take = flags.r_zero;
            C_DIV_BUSY: take = !flags.div_done;
            C_NOT_LAST: take = !flags.last;
            C_OUT_BUSY: take = flags.out_busy;
            default:    take = 1'b1;
        endcase
        step_next = take ? word.target : step_reg + 1'b1;
        uop       = word.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end
endmodule

// File: rtl/postfix_expression_evaluator.sv
// postfix expression evaluator: top level with datapath, stack ram and divider
// a digit, a separator and an operator each run their own microcode steps; / waits on the iterative divider
// the final character then flushes any pending number, reads the top of stack and offers the result
// throughput: one character in flight; set by the microcode step sequence and the divider
// a waiting result does not block new characters until the next expression ends
// reset: asynchronous active low; stack empty, no number pending, status clear
module postfix_expression_evaluator (
    input  logic clk,
    input  logic rst_n,
    pfe_char_if.sink     expr,
    pfe_result_if.source result
);
    import pfe_pkg::*;

    uop_t       uop;
    seq_flags_t flags;

    // per-expression state
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              in_num_reg, in_num_next;
    status_t           err_reg, err_next;

    // current character transaction
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;

    // operands and result
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] l_reg, l_next;
    logic [DATA_W-1:0] res_reg, res_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg, value_next;
    status_t           status_reg, status_next;

    // stack ram controls
    logic                we;
    logic [STACK_AW-1:0] waddr;
    logic [DATA_W-1:0]   wdata;
    logic                re;
    logic [STACK_AW-1:0] raddr;
    logic [DATA_W-1:0]   rdata;

    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic              full;
    logic              out_busy;
    logic              is_digit;
    logic [ACC_W+3:0]  acc_x10;
    logic [DATA_W-1:0] mul_lo;

    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign full     = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign out_busy = out_valid_reg && !result.ready;
    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);

    // acc * 10 + digit, in shifts and adds, never overflows the wide sum
    assign acc_x10  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + {{(ACC_W){1'b0}}, char_reg[3:0] - CH_ZERO[3:0]};
    assign mul_lo   = l_reg * r_reg;

    assign flags.in_valid = expr.valid;
    assign flags.is_digit = is_digit;
    assign flags.is_oper  = (char_reg == CH_STAR) || (char_reg == CH_PLUS)
                         || (char_reg == CH_MINUS) || (char_reg == CH_SLASH);
    assign flags.is_div   = (char_reg == CH_SLASH);
    assign flags.few      = (cnt_reg < CNT_W'(2));
    assign flags.r_zero   = (r_reg == '0);
    assign flags.div_done = div_done;
    assign flags.last     = last_reg;
    assign flags.out_busy = out_busy;

    pfe_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uop   (uop)
    );

    pfe_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    pfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (l_reg),
        .divisor  (r_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign expr.ready = (uop == U_ACCEPT);

    // datapath actions selected by the current control word
    always_comb
    begin
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        in_num_next    = in_num_reg;
        err_next       = err_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        r_next         = r_reg;
        l_next         = l_reg;
        res_next       = res_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !result.ready;
        we             = 1'b0;
        waddr          = cnt_reg[STACK_AW-1:0];
        wdata          = res_reg;
        re             = 1'b0;
        raddr          = cnt_m1[STACK_AW-1:0];
        div_start      = 1'b0;

        unique case (uop)
            U_NOP:
            begin
            end
            U_ACCEPT:
            begin
                if (expr.valid)
                begin
                    char_next = expr.char_code;
                    last_next = expr.end_of_expr;
                end
            end
            U_DIGIT:
            begin
                if (is_digit)
                begin
                    in_num_next = 1'b1;
                    if (!in_num_reg)
                    begin
                        acc_next = ACC_W'(char_reg - CH_ZERO);
                    end
                    else if (acc_x10 > {4'b0, NUM_MAX})
                    begin
                        acc_next = NUM_MAX;
                    end
                    else
                    begin
                        acc_next = acc_x10[ACC_W-1:0];
                    end
                end
            end
            U_FLUSH:
            begin
                // push the pending number, if any
                if (in_num_reg)
                begin
                    in_num_next = 1'b0;
                    acc_next    = '0;
                    wdata       = {1'b0, acc_reg};
                    if (full)
                    begin
                        if (err_reg == ST_OK)
                        begin
                            err_next = ST_OVER;
                        end
                    end
                    else
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            U_READ_R:
            begin
                if (cnt_reg < CNT_W'(2))
                begin
                    if (err_reg == ST_OK)
                    begin
                        err_next = ST_UNDER;
                    end
                end
                else
                begin
                    re = 1'b1;
                end
            end
            U_READ_L:
            begin
                r_next = rdata;
                re     = 1'b1;
                raddr  = cnt_m2[STACK_AW-1:0];
            end
            U_POP:
            begin
                l_next   = rdata;
                cnt_next = cnt_m2;
            end
            U_ALU:
            begin
                case (char_reg)
                    CH_STAR:  res_next = mul_lo;
                    CH_PLUS:  res_next = l_reg + r_reg;
                    CH_MINUS: res_next = l_reg - r_reg;
                    default:  res_next = '0;
                endcase
            end
            U_DIV_GO:
            begin
                if (r_reg == '0)
                begin
                    res_next = '0;
                    if (err_reg == ST_OK)
                    begin
                        err_next = ST_DIVZ;
                    end
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            U_DIV_TAKE:
            begin
                if (div_done)
                begin
                    res_next = div_quo;
                end
            end
            U_PUSH_RES:
            begin
                if (full)
                begin
                    if (err_reg == ST_OK)
                    begin
                        err_next = ST_OVER;
                    end
                end
                else
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            U_READ_TOP:
            begin
                re = 1'b1;
            end
            U_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        value_next  = '0;
                        status_next = (err_reg == ST_OK) ? ST_UNDER : err_reg;
                    end
                    else
                    begin
                        value_next  = rdata;
                        status_next = err_reg;
                    end
                    // back to the empty state for the next expression
                    cnt_next    = '0;
                    acc_next    = '0;
                    in_num_next = 1'b0;
                    err_next    = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            acc_reg       <= '0;
            in_num_reg    <= 1'b0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            in_num_reg    <= in_num_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        last_reg   <= last_next;
        r_reg      <= r_next;
        l_reg      <= l_next;
        res_reg    <= res_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.value  = value_reg;
    assign result.status = status_reg;
endmodule

// File: rtl/pfe_checker.sv
// port-level checks of the postfix evaluator and their bind
module pfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       expr_valid,
    input logic       expr_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [1:0] result_status
);
    logic expr_take;

    assign expr_take = expr_valid && expr_ready;

    // a result waiting on the sink stays offered
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result transaction withdrawn before it was taken");

    // the block never accepts two characters back to back
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        expr_take |=> !expr_ready)
        else $error("character accepted in the cycle after another");

    // a new result only appears while the character side is held off
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(expr_ready) && !$past(expr_take))
        else $error("result raised without the evaluation steps");

    // status of a stalled result does not change
    a_status_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_status))
        else $error("result status changed while stalled");
endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .expr_valid    (expr.valid),
    .expr_ready    (expr.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_status (result.status)
);

// File: bench/postfix_expression_evaluator_checker.sv
// checker for the postfix evaluator: predicts each result and compares it with the block
module postfix_expression_evaluator_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    input  logic               char_ready,
    input  logic [7:0]         char_code,
    input  logic               char_last,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic signed [31:0] res_value,
    input  pfe_pkg::status_t   res_status,
    output int                 errors,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic signed [31:0] value;
        status_t            status;
    } expr_result_t;

    // predicted evaluator state
    logic [31:0]  opnd_stack [STACK_DEPTH];
    int           opnd_depth;
    logic [31:0]  num_acc;
    bit           num_active;
    status_t      first_error;

    expr_result_t results [$];

    function automatic void clear_evaluator();
        foreach (opnd_stack[i]) opnd_stack[i] = '0;
        opnd_depth  = 0;
        num_acc     = '0;
        num_active  = 1'b0;
        first_error = ST_OK;
    endfunction

    function automatic void record_error(input status_t code);
        if (first_error == ST_OK)
            first_error = code;
    endfunction

    function automatic void push_operand(input logic [31:0] v);
        if (opnd_depth >= STACK_DEPTH)
        begin
            record_error(ST_OVER);
        end
        else
        begin
            opnd_stack[opnd_depth] = v;
            opnd_depth++;
        end
    endfunction

    function automatic void flush_number();
        if (num_active)
        begin
            push_operand(num_acc);
            num_active = 1'b0;
            num_acc    = '0;
        end
    endfunction

    // one character in; returns 1 when the character ends an expression
    function automatic bit eval_char(input logic [7:0] c, input bit last,
                                     output expr_result_t res);
        logic [7:0]  d;
        logic [63:0] n;
        logic [31:0] l, r, word;
        longint      quot;
        res.value  = '0;
        res.status = ST_OK;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
            if (!num_active)
            begin
                num_acc    = {24'd0, d};
                num_active = 1'b1;
            end
            else
            begin
                n       = {32'd0, num_acc} * 64'd10 + {56'd0, d};
                num_acc = (n > {32'd0, SAT_MAX}) ? SAT_MAX : n[31:0];
            end
        end
        else
        begin
            flush_number();
            if (c == CH_STAR || c == CH_PLUS || c == CH_MINUS || c == CH_SLASH)
            begin
                if (opnd_depth < 2)
                begin
                    record_error(ST_UNDER);
                end
                else
                begin
                    r = opnd_stack[opnd_depth - 1];
                    l = opnd_stack[opnd_depth - 2];
                    opnd_depth -= 2;
                    if (c == CH_STAR)
                        word = l * r;
                    else if (c == CH_PLUS)
                        word = l + r;
                    else if (c == CH_MINUS)
                        word = l - r;
                    else if (r == '0)
                    begin
                        record_error(ST_DIVZ);
                        word = '0;
                    end
                    else
                    begin
                        // 64-bit quotient so that min / -1 wraps cleanly
                        quot = longint'($signed(l)) / longint'($signed(r));
                        word = quot[31:0];
                    end
                    push_operand(word);
                end
            end
        end
        if (!last)
            return 1'b0;
        flush_number();
        if (opnd_depth == 0)
        begin
            record_error(ST_UNDER);
            res.value = '0;
        end
        else
        begin
            res.value = opnd_stack[opnd_depth - 1];
        end
        res.status = first_error;
        clear_evaluator();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        expr_result_t want;
        if (!rst_n)
        begin
            clear_evaluator();
            results.delete();
            errors      = 0;
            outstanding <= 0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                if (eval_char(char_code, char_last, want))
                    results.push_back(want);
            end
            if (res_valid && res_ready)
            begin
                if (results.size() == 0)
                begin
                    $error("result transaction with no expected value: value %0d, status %0d",
                           res_value, res_status);
                    errors++;
                end
                else
                begin
                    want = results.pop_front();
                    if (res_value !== want.value)
                    begin
                        $error("value mismatch: expected %0d, actual %0d",
                               want.value, res_value);
                        errors++;
                    end
                    if (res_status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, res_status);
                        errors++;
                    end
                end
            end
            outstanding <= results.size();
        end
    end

endmodule

// File: bench/postfix_expression_evaluator_tb.sv
// top of the postfix evaluator bench: clock, reset, character stimulus and verdict
module postfix_expression_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    localparam int         ITEMS       = 1750;
    localparam int         STALL_LIMIT = 4000;
    localparam int         DRAIN_WAIT  = 64;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // idle percentages of the sender and the receiver, changed per phase
    int src_idle  = 11;
    int sink_idle = 72;

    int items_sent   = 0;
    int stall_cycles = 0;
    bit timed_out    = 1'b0;
    int error_count;
    int pending;

    // characters of the expression being built, the last one carries end_of_expr
    logic [7:0] text [$];

    pfe_char_if   expr_ch ();
    pfe_result_if result_ch ();

    postfix_expression_evaluator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .expr   (expr_ch),
        .result (result_ch)
    );

    postfix_expression_evaluator_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (expr_ch.valid),
        .char_ready  (expr_ch.ready),
        .char_code   (expr_ch.char_code),
        .char_last   (expr_ch.end_of_expr),
        .res_valid   (result_ch.valid),
        .res_ready   (result_ch.ready),
        .res_value   (result_ch.value),
        .res_status  (result_ch.status),
        .errors      (error_count),
        .outstanding (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side: random back-pressure on the result channel
    always @(posedge clk)
    begin
        if (rst_n)
            result_ch.ready <= ($urandom_range(99) >= sink_idle);
    end

    // watchdog: cycles since the last transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (expr_ch.valid && expr_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // one character transaction, with random idle cycles in front of it
    task automatic send_char(input logic [7:0] c, input bit last);
        while ($urandom_range(99) < src_idle)
        begin
            expr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        expr_ch.valid       <= 1'b1;
        expr_ch.char_code   <= c;
        expr_ch.end_of_expr <= last;
        @(posedge clk);
        while (!expr_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // send the built expression, end_of_expr on its final character
    task automatic send_text();
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
        text.delete();
    endtask

    // hold the sender off until every predicted result has come back
    task automatic wait_for_results();
        expr_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic void queue_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    function automatic void add_number(input logic [63:0] v);
        logic [7:0] digits [$];
        do
        begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digits[i])
            text.push_back(digits[i]);
    endfunction

    // separator: mostly a space, sometimes any other code that is neither digit nor operator
    function automatic void add_sep();
        logic [7:0] c;
        if ($urandom_range(4) != 0)
            c = CH_SPACE;
        else
        begin
            do
                c = 8'($urandom_range(255));
            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_STAR || c == CH_PLUS ||
                   c == CH_MINUS || c == CH_SLASH);
        end
        text.push_back(c);
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(3))
            0:       return CH_STAR;
            1:       return CH_PLUS;
            2:       return CH_MINUS;
            default: return CH_SLASH;
        endcase
    endfunction

    // random well-formed postfix expression with n operands
    function automatic void add_wellformed(input int n);
        int          operands_left;
        int          depth;
        bit          after_number;
        logic [63:0] v;
        operands_left = n;
        depth         = 0;
        after_number  = 1'b0;
        while (operands_left > 0 || depth > 1)
        begin
            if (operands_left > 0 && (depth < 2 || $urandom_range(1) == 0))
            begin
                // two numbers in a row need something between them
                if (after_number || $urandom_range(3) == 0)
                    add_sep();
                case ($urandom_range(9))
                    0:       v = 64'd0;
                    1:       v = 64'd1;
                    2:       v = 64'd2147483647;
                    3:       v = {32'd0, $urandom};
                    4:       v = {28'd0, 4'($urandom_range(9)), $urandom};
                    5:       v = 64'($urandom_range(9));
                    default: v = 64'($urandom_range(999));
                endcase
                add_number(v);
                operands_left--;
                depth++;
                after_number = 1'b1;
            end
            else
            begin
                if ($urandom_range(2) == 0)
                    add_sep();
                text.push_back(pick_operator());
                depth--;
                after_number = 1'b0;
            end
        end
    endfunction

    initial
    begin
        expr_ch.valid       = 1'b0;
        expr_ch.char_code   = 8'd0;
        expr_ch.end_of_expr = 1'b0;
        result_ch.ready     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            begin
                int kind;
                int phase;
                int count;
                phase = 0;

                // directed: every operator, edge codes and the underflow and divide-by-zero cases
                queue_str("7 2/");       // plain division
                send_text();
                queue_str("9 0/");       // divide by zero
                send_text();
                queue_str("4 5+9-");     // sum then a zero difference
                send_text();
                queue_str("6 7*");
                send_text();
                queue_str("+");          // operator on an empty stack, then empty at the end
                send_text();
                text.push_back(8'd0);    // lowest code, ignored, empty stack
                send_text();
                queue_str("5");          // pending number flushed by the highest code
                text.push_back(8'hFF);
                send_text();
                queue_str("1 5");        // entry left below the top, number ends with the expression
                send_text();

                // random expressions, three idling phases
                while (items_sent < ITEMS)
                begin
                    if (phase == 0 && items_sent >= ITEMS / 3)
                    begin
                        phase = 1;
                        wait_for_results();
                        src_idle  = 72;
                        sink_idle = 11;
                    end
                    else if (phase == 1 && items_sent >= 2 * ITEMS / 3)
                    begin
                        phase = 2;
                        wait_for_results();
                        src_idle  = 0;
                        sink_idle = 0;
                    end

                    kind = $urandom_range(99);
                    if (kind < 70)
                        add_wellformed($urandom_range(1, 6));
                    else if (kind < 80)
                    begin
                        // broken expression: a token dropped or a stray operator
                        add_wellformed($urandom_range(1, 5));
                        if ($urandom_range(1) == 0 && text.size() > 1)
                            text.delete($urandom_range(text.size() - 1));
                        else
                            text.insert($urandom_range(text.size()), pick_operator());
                    end
                    else if (kind < 92)
                    begin
                        // noise, digits and operators mixed with any code
                        count = $urandom_range(1, 8);
                        repeat (count)
                        begin
                            case ($urandom_range(3))
                                0:       text.push_back(CH_ZERO + 8'($urandom_range(9)));
                                1:       text.push_back(pick_operator());
                                default: text.push_back(8'($urandom_range(255)));
                            endcase
                        end
                    end
                    else if (kind < 96)
                        queue_str("2147483647 1+0 1-/");   // most negative by -1
                    else if (kind < 99)
                    begin
                        // long number, often past the saturation point
                        text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
                        count = $urandom_range(9, 13);
                        repeat (count)
                            text.push_back(CH_ZERO + 8'($urandom_range(9)));
                        if ($urandom_range(1) == 0)
                            queue_str(" 1+");
                    end
                    else
                    begin
                        // fill the stack around its depth to hit overflow
                        count = STACK_DEPTH - 1 + $urandom_range(3);
                        repeat (count)
                        begin
                            add_number(64'($urandom_range(9)));
                            add_sep();
                        end
                        repeat ($urandom_range(2))
                            text.push_back(CH_PLUS);
                    end

                    // sometimes the end marker rides on a trailing separator
                    if ($urandom_range(3) == 0)
                        add_sep();
                    send_text();
                end

                wait_for_results();
                repeat (DRAIN_WAIT) @(posedge clk);
            end
            begin
                wait (stall_cycles >= STALL_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
